// ===== hdl/hsv_to_rgb_converter_core_assert.svh =====
// Assertion macros shared by the colour converter RTL.
`ifndef HSV_TO_RGB_CONVERTER_CORE_ASSERT_SVH
`define HSV_TO_RGB_CONVERTER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HSVC_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("hsv_to_rgb_converter_core: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define HSVC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("hsv_to_rgb_converter_core: next-cycle check failed");

`endif

// ===== hdl/hsvc_pkg.sv =====
// Types and constants shared by the colour converter pipeline.
`default_nettype none

package hsvc_pkg;

   localparam int unsigned SECTOR_DEG = 60;
   localparam int unsigned FULL_LEVEL = 255;
   localparam int unsigned FULL_TURN  = 360;
   localparam int unsigned DEN        = FULL_LEVEL * SECTOR_DEG;

   // The level and denominator reciprocals sit slightly below the true value, so an
   // estimate is exact or one low. The sector reciprocal sits just above and is exact
   // for every nine-bit hue.
   localparam int unsigned RECIP_SECTOR       = 1093;
   localparam int unsigned RECIP_SECTOR_SHIFT = 16;
   localparam int unsigned RECIP_LEVEL        = 257;
   localparam int unsigned RECIP_LEVEL_SHIFT  = 16;
   localparam int unsigned RECIP_DEN          = 70179;
   localparam int unsigned RECIP_DEN_SHIFT    = 30;

   typedef logic [8:0]  hue_type;
   typedef logic [7:0]  level_type;
   typedef logic [5:0]  rem_type;
   typedef logic [3:0]  sector_type;
   typedef logic [13:0] num_type;
   typedef logic [15:0] narrow_type;
   typedef logic [21:0] wide_type;

   localparam sector_type SECT_RED     = 4'd0;
   localparam sector_type SECT_YELLOW  = 4'd1;
   localparam sector_type SECT_GREEN   = 4'd2;
   localparam sector_type SECT_CYAN    = 4'd3;
   localparam sector_type SECT_BLUE    = 4'd4;

   typedef struct packed {
      sector_type sector;
      rem_type    rem;
      level_type  sat;
      level_type  bright;
   } hue_stage_type;

   typedef struct packed {
      sector_type sector;
      level_type  bright;
      level_type  sat_inv;
      num_type    num_q;
      num_type    num_t;
   } num_stage_type;

   typedef struct packed {
      sector_type sector;
      level_type  bright;
      narrow_type p_x;
      wide_type   q_x;
      wide_type   t_x;
   } prod_stage_type;

   typedef struct packed {
      sector_type sector;
      level_type  bright;
      narrow_type p_x;
      wide_type   q_x;
      wide_type   t_x;
      level_type  p_est;
      level_type  q_est;
      level_type  t_est;
   } est_stage_type;

   typedef struct packed {
      sector_type sector;
      level_type  bright;
      level_type  p_lvl;
      level_type  q_lvl;
      level_type  t_lvl;
   } tone_stage_type;

endpackage

`default_nettype wire

// ===== hdl/hsvc_sector.sv =====
// First pipeline stage: splits the hue into a sector and an offset within it.
`default_nettype none

module hsvc_sector (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   up_valid,
   output logic                        up_stall,
   input  wire hsvc_pkg::hue_type      hue_degrees,
   input  wire hsvc_pkg::level_type    sat_level,
   input  wire hsvc_pkg::level_type    bright_level,
   output logic                        dn_valid,
   input  wire logic                   dn_stall,
   output hsvc_pkg::hue_stage_type     dn_data
);

   logic                    valid_ff;
   logic                    stage_en;
   hsvc_pkg::hue_stage_type data_ff;
   hsvc_pkg::hue_stage_type data_in;
   hsvc_pkg::hue_type       hue_adj;
   logic [19:0]             hue_prod;
   logic [9:0]              sect_deg;

   assign stage_en = !valid_ff || !dn_stall;
   assign up_stall = !stage_en;
   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

   always_comb begin
      // A full turn is the same colour as zero degrees.
      hue_adj = (hue_degrees == hsvc_pkg::hue_type'(hsvc_pkg::FULL_TURN)) ? '0 : hue_degrees;
      hue_prod = 20'(hue_adj) * 20'(hsvc_pkg::RECIP_SECTOR);
      data_in.sector = hsvc_pkg::sector_type'(hue_prod >> hsvc_pkg::RECIP_SECTOR_SHIFT);
      sect_deg = 10'(data_in.sector) * 10'(hsvc_pkg::SECTOR_DEG);
      data_in.rem = hsvc_pkg::rem_type'(10'(hue_adj) - sect_deg);
      data_in.sat = sat_level;
      data_in.bright = bright_level;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (stage_en) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/hsvc_scale.sv =====
// Second and third pipeline stages: numerators of p, q and t, then scaling by value.
`default_nettype none

module hsvc_scale (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     up_valid,
   output logic                          up_stall,
   input  wire hsvc_pkg::hue_stage_type  up_data,
   output logic                          dn_valid,
   input  wire logic                     dn_stall,
   output hsvc_pkg::prod_stage_type      dn_data
);

   logic                     num_valid_ff;
   logic                     prod_valid_ff;
   logic                     num_en;
   logic                     prod_en;
   hsvc_pkg::num_stage_type  num_ff;
   hsvc_pkg::num_stage_type  num_in;
   hsvc_pkg::prod_stage_type prod_ff;
   hsvc_pkg::prod_stage_type prod_in;
   hsvc_pkg::rem_type        rem_inv;
   hsvc_pkg::num_type        sat_rem;
   hsvc_pkg::num_type        sat_rem_inv;

   assign prod_en  = !prod_valid_ff || !dn_stall;
   assign num_en   = !num_valid_ff || prod_en;
   assign up_stall = !num_en;
   assign dn_valid = prod_valid_ff;
   assign dn_data  = prod_ff;

   always_comb begin
      rem_inv = hsvc_pkg::rem_type'(hsvc_pkg::SECTOR_DEG) - up_data.rem;
      sat_rem = 14'(up_data.sat) * 14'(up_data.rem);
      sat_rem_inv = 14'(up_data.sat) * 14'(rem_inv);
      num_in.sector = up_data.sector;
      num_in.bright = up_data.bright;
      num_in.sat_inv = hsvc_pkg::level_type'(hsvc_pkg::FULL_LEVEL) - up_data.sat;
      num_in.num_q = hsvc_pkg::num_type'(hsvc_pkg::DEN) - sat_rem;
      num_in.num_t = hsvc_pkg::num_type'(hsvc_pkg::DEN) - sat_rem_inv;
   end

   always_comb begin
      prod_in.sector = num_ff.sector;
      prod_in.bright = num_ff.bright;
      prod_in.p_x = 16'(num_ff.bright) * 16'(num_ff.sat_inv);
      prod_in.q_x = 22'(num_ff.bright) * 22'(num_ff.num_q);
      prod_in.t_x = 22'(num_ff.bright) * 22'(num_ff.num_t);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_valid_ff  <= 1'b0;
         prod_valid_ff <= 1'b0;
      end else begin
         if (num_en) begin
            num_valid_ff <= up_valid;
         end
         if (prod_en) begin
            prod_valid_ff <= num_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (num_en) begin
         num_ff <= num_in;
      end
      if (prod_en) begin
         prod_ff <= prod_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/hsvc_divide.sv =====
// Fourth and fifth pipeline stages: division by constants via reciprocal and correction.
`default_nettype none

module hsvc_divide (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     up_valid,
   output logic                          up_stall,
   input  wire hsvc_pkg::prod_stage_type up_data,
   output logic                          dn_valid,
   input  wire logic                     dn_stall,
   output hsvc_pkg::tone_stage_type      dn_data
);

   logic                     est_valid_ff;
   logic                     tone_valid_ff;
   logic                     est_en;
   logic                     tone_en;
   hsvc_pkg::est_stage_type  est_ff;
   hsvc_pkg::est_stage_type  est_in;
   hsvc_pkg::tone_stage_type tone_ff;
   hsvc_pkg::tone_stage_type tone_in;
   logic [24:0]              p_prod;
   logic [38:0]              q_prod;
   logic [38:0]              t_prod;
   hsvc_pkg::narrow_type     p_rem;
   hsvc_pkg::wide_type       q_rem;
   hsvc_pkg::wide_type       t_rem;

   assign tone_en  = !tone_valid_ff || !dn_stall;
   assign est_en   = !est_valid_ff || tone_en;
   assign up_stall = !est_en;
   assign dn_valid = tone_valid_ff;
   assign dn_data  = tone_ff;

   always_comb begin
      p_prod = 25'(up_data.p_x) * 25'(hsvc_pkg::RECIP_LEVEL);
      q_prod = 39'(up_data.q_x) * 39'(hsvc_pkg::RECIP_DEN);
      t_prod = 39'(up_data.t_x) * 39'(hsvc_pkg::RECIP_DEN);
      est_in.sector = up_data.sector;
      est_in.bright = up_data.bright;
      est_in.p_x = up_data.p_x;
      est_in.q_x = up_data.q_x;
      est_in.t_x = up_data.t_x;
      est_in.p_est = hsvc_pkg::level_type'(p_prod >> hsvc_pkg::RECIP_LEVEL_SHIFT);
      est_in.q_est = hsvc_pkg::level_type'(q_prod >> hsvc_pkg::RECIP_DEN_SHIFT);
      est_in.t_est = hsvc_pkg::level_type'(t_prod >> hsvc_pkg::RECIP_DEN_SHIFT);
   end

   // The estimates are never high; a remainder at or above the divisor means one low.
   always_comb begin
      p_rem = est_ff.p_x - 16'(est_ff.p_est) * 16'(hsvc_pkg::FULL_LEVEL);
      q_rem = est_ff.q_x - 22'(est_ff.q_est) * 22'(hsvc_pkg::DEN);
      t_rem = est_ff.t_x - 22'(est_ff.t_est) * 22'(hsvc_pkg::DEN);
      tone_in.sector = est_ff.sector;
      tone_in.bright = est_ff.bright;
      tone_in.p_lvl = (p_rem >= 16'(hsvc_pkg::FULL_LEVEL)) ? est_ff.p_est + 8'd1 : est_ff.p_est;
      tone_in.q_lvl = (q_rem >= 22'(hsvc_pkg::DEN)) ? est_ff.q_est + 8'd1 : est_ff.q_est;
      tone_in.t_lvl = (t_rem >= 22'(hsvc_pkg::DEN)) ? est_ff.t_est + 8'd1 : est_ff.t_est;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         est_valid_ff  <= 1'b0;
         tone_valid_ff <= 1'b0;
      end else begin
         if (est_en) begin
            est_valid_ff <= up_valid;
         end
         if (tone_en) begin
            tone_valid_ff <= est_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (est_en) begin
         est_ff <= est_in;
      end
      if (tone_en) begin
         tone_ff <= tone_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/hsv_to_rgb_converter_core.sv =====
// Top level of the HSV to RGB colour converter pipeline.
//
//   Channel | Direction | Handshake         | Item contents
//   req     | in        | req_valid/stall   | hue_degrees, sat_level, bright_level
//   rsp     | out       | rsp_valid/stall   | red_out, green_out, blue_out
//
// One item is accepted per clock while req_stall is low.
// The six register stages are: sector split, numerators, value products,
// reciprocal estimates, correction, and the colour routing output register.
// Reset (synchronous, active high) clears every stage's valid bit.
// Each stage holds only while it is full and the stage after it holds, so empty
// stages close up behind a stalled result and input is taken until the pipe is full.
`default_nettype none
`include "hsv_to_rgb_converter_core_assert.svh"

module hsv_to_rgb_converter_core (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire hsvc_pkg::hue_type   req_hue_degrees,
   input  wire hsvc_pkg::level_type req_sat_level,
   input  wire hsvc_pkg::level_type req_bright_level,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output hsvc_pkg::level_type      rsp_red_out,
   output hsvc_pkg::level_type      rsp_green_out,
   output hsvc_pkg::level_type      rsp_blue_out
);

   logic                     hue_valid;
   logic                     hue_stall;
   hsvc_pkg::hue_stage_type  hue_data;
   logic                     prod_valid;
   logic                     prod_stall;
   hsvc_pkg::prod_stage_type prod_data;
   logic                     tone_valid;
   logic                     tone_stall;
   hsvc_pkg::tone_stage_type tone;
   logic                     out_en;
   logic                     rsp_valid_ff;
   hsvc_pkg::level_type      red_ff;
   hsvc_pkg::level_type      green_ff;
   hsvc_pkg::level_type      blue_ff;
   hsvc_pkg::level_type      red_in;
   hsvc_pkg::level_type      green_in;
   hsvc_pkg::level_type      blue_in;

   hsvc_sector u_sector (
      .clock        (clock),
      .reset        (reset),
      .up_valid     (req_valid),
      .up_stall     (req_stall),
      .hue_degrees  (req_hue_degrees),
      .sat_level    (req_sat_level),
      .bright_level (req_bright_level),
      .dn_valid     (hue_valid),
      .dn_stall     (hue_stall),
      .dn_data      (hue_data)
   );

   hsvc_scale u_scale (
      .clock    (clock),
      .reset    (reset),
      .up_valid (hue_valid),
      .up_stall (hue_stall),
      .up_data  (hue_data),
      .dn_valid (prod_valid),
      .dn_stall (prod_stall),
      .dn_data  (prod_data)
   );

   hsvc_divide u_divide (
      .clock    (clock),
      .reset    (reset),
      .up_valid (prod_valid),
      .up_stall (prod_stall),
      .up_data  (prod_data),
      .dn_valid (tone_valid),
      .dn_stall (tone_stall),
      .dn_data  (tone)
   );

   assign out_en     = !rsp_valid_ff || !rsp_stall;
   assign tone_stall = !out_en;

   // Sectors beyond blue, including hues above a full turn, take the magenta mapping.
   always_comb begin
      unique case (tone.sector)
         hsvc_pkg::SECT_RED: begin
            red_in = tone.bright; green_in = tone.t_lvl; blue_in = tone.p_lvl;
         end
         hsvc_pkg::SECT_YELLOW: begin
            red_in = tone.q_lvl; green_in = tone.bright; blue_in = tone.p_lvl;
         end
         hsvc_pkg::SECT_GREEN: begin
            red_in = tone.p_lvl; green_in = tone.bright; blue_in = tone.t_lvl;
         end
         hsvc_pkg::SECT_CYAN: begin
            red_in = tone.p_lvl; green_in = tone.q_lvl; blue_in = tone.bright;
         end
         hsvc_pkg::SECT_BLUE: begin
            red_in = tone.t_lvl; green_in = tone.p_lvl; blue_in = tone.bright;
         end
         default: begin
            red_in = tone.bright; green_in = tone.p_lvl; blue_in = tone.q_lvl;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_en) begin
         rsp_valid_ff <= tone_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_en) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_red_out   = red_ff;
   assign rsp_green_out = green_ff;
   assign rsp_blue_out  = blue_ff;

   `HSVC_ASSERT_NEXT(a_accept_fills_first, req_valid && !req_stall, hue_valid)
   `HSVC_ASSERT_IMPLY(a_tone_order, tone_valid, (tone.p_lvl <= tone.q_lvl) && (tone.p_lvl <= tone.t_lvl))
   `HSVC_ASSERT_IMPLY(a_tone_bounded, tone_valid, (tone.q_lvl <= tone.bright) && (tone.t_lvl <= tone.bright))

endmodule

`default_nettype wire

// ===== tb/sv/tb_hsv_to_rgb_checker.sv =====
// Checker that predicts each colour from the accepted HSV item and compares the results.
`timescale 1ns / 1ps

module tb_hsv_to_rgb_checker (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  hsvc_pkg::hue_type   req_hue_degrees,
   input  hsvc_pkg::level_type req_sat_level,
   input  hsvc_pkg::level_type req_bright_level,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  hsvc_pkg::level_type rsp_red_out,
   input  hsvc_pkg::level_type rsp_green_out,
   input  hsvc_pkg::level_type rsp_blue_out,
   output int                  colours_pending,
   output int                  fail_count
);

   typedef struct packed {
      hsvc_pkg::level_type red;
      hsvc_pkg::level_type green;
      hsvc_pkg::level_type blue;
   } rgb_pixel_type;

   rgb_pixel_type expected_colours[$];

   // Each channel is 255 times its real value, truncated, computed with exact integer ratios.
   function automatic rgb_pixel_type convert_hsv(hsvc_pkg::hue_type hue,
                                                 hsvc_pkg::level_type sat,
                                                 hsvc_pkg::level_type bright);
      int unsigned          h;
      int unsigned          s;
      int unsigned          v;
      int unsigned          rem;
      int unsigned          p;
      int unsigned          q;
      int unsigned          t;
      hsvc_pkg::level_type  lv;
      hsvc_pkg::level_type  lp;
      hsvc_pkg::level_type  lq;
      hsvc_pkg::level_type  lt;
      hsvc_pkg::sector_type sector;
      rgb_pixel_type        pix;
      h = hue;
      s = sat;
      v = bright;
      if (s == 0) begin
         pix = '{bright, bright, bright};
      end else begin
         if (h == hsvc_pkg::FULL_TURN) begin
            h = 0;
         end
         sector = hsvc_pkg::sector_type'(h / hsvc_pkg::SECTOR_DEG);
         rem    = h % hsvc_pkg::SECTOR_DEG;
         p = (v * (hsvc_pkg::FULL_LEVEL - s)) / hsvc_pkg::FULL_LEVEL;
         q = (v * (hsvc_pkg::DEN - s * rem)) / hsvc_pkg::DEN;
         t = (v * (hsvc_pkg::DEN - s * (hsvc_pkg::SECTOR_DEG - rem))) / hsvc_pkg::DEN;
         lv = hsvc_pkg::level_type'(v);
         lp = hsvc_pkg::level_type'(p);
         lq = hsvc_pkg::level_type'(q);
         lt = hsvc_pkg::level_type'(t);
         case (sector)
            hsvc_pkg::SECT_RED: begin
               pix = '{lv, lt, lp};
            end
            hsvc_pkg::SECT_YELLOW: begin
               pix = '{lq, lv, lp};
            end
            hsvc_pkg::SECT_GREEN: begin
               pix = '{lp, lv, lt};
            end
            hsvc_pkg::SECT_CYAN: begin
               pix = '{lp, lq, lv};
            end
            hsvc_pkg::SECT_BLUE: begin
               pix = '{lt, lp, lv};
            end
            // Sector five and the hues beyond a full turn share this routing.
            default: begin
               pix = '{lv, lp, lq};
            end
         endcase
      end
      return pix;
   endfunction

   function automatic int field_mismatch(string name, hsvc_pkg::level_type expected,
                                         hsvc_pkg::level_type actual);
      if (expected !== actual) begin
         $error("%s: expected %0d, got %0d", name, expected, actual);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin
      rgb_pixel_type want;
      int            errors;
      errors = 0;
      if (reset) begin
         colours_pending <= 0;
         fail_count      <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_colours.size() == 0) begin
               $error("colour item arrived with none outstanding: %0d %0d %0d",
                      rsp_red_out, rsp_green_out, rsp_blue_out);
               errors = 1;
            end else begin
               want   = expected_colours.pop_front();
               errors = field_mismatch("red_out", want.red, rsp_red_out)
                      + field_mismatch("green_out", want.green, rsp_green_out)
                      + field_mismatch("blue_out", want.blue, rsp_blue_out);
            end
         end
         if (req_valid && !req_stall) begin
            expected_colours.push_back(convert_hsv(req_hue_degrees, req_sat_level,
                                                   req_bright_level));
         end
         colours_pending <= expected_colours.size();
         fail_count      <= fail_count + errors;
      end
   end

endmodule

// ===== tb/sv/tb_hsv_to_rgb_converter_core.sv =====
// Top of the colour converter testbench: clock, reset, HSV stimulus and the verdict.
`timescale 1ns / 1ps

module tb_hsv_to_rgb_converter_core;

   localparam int QUIET_LIMIT  = 5000;
   localparam int DRAIN_CYCLES = 20;
   localparam int RANDOM_ITEMS = 1050;

   logic                clock;
   logic                reset            = 1'b1;
   logic                req_valid        = 1'b0;
   logic                req_stall;
   hsvc_pkg::hue_type   req_hue_degrees  = '0;
   hsvc_pkg::level_type req_sat_level    = '0;
   hsvc_pkg::level_type req_bright_level = '0;
   logic                rsp_valid;
   logic                rsp_stall        = 1'b0;
   hsvc_pkg::level_type rsp_red_out;
   hsvc_pkg::level_type rsp_green_out;
   hsvc_pkg::level_type rsp_blue_out;

   int colours_pending;
   int fail_count;
   int idle_pct    = 0;
   int stall_pct   = 0;
   int quiet_count = 0;

   hsv_to_rgb_converter_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_hue_degrees  (req_hue_degrees),
      .req_sat_level    (req_sat_level),
      .req_bright_level (req_bright_level),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_red_out      (rsp_red_out),
      .rsp_green_out    (rsp_green_out),
      .rsp_blue_out     (rsp_blue_out)
   );

   tb_hsv_to_rgb_checker checker_inst (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_hue_degrees  (req_hue_degrees),
      .req_sat_level    (req_sat_level),
      .req_bright_level (req_bright_level),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_red_out      (rsp_red_out),
      .rsp_green_out    (rsp_green_out),
      .rsp_blue_out     (rsp_blue_out),
      .colours_pending  (colours_pending),
      .fail_count       (fail_count)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // The run is abandoned when neither channel has moved an item for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_count <= 0;
      end else if (quiet_count >= QUIET_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         quiet_count <= quiet_count + 1;
      end
   end

   // Valid is only lowered for an idle gap, never between two back-to-back items.
   task automatic send_pixel(input hsvc_pkg::hue_type hue, input hsvc_pkg::level_type sat,
                             input hsvc_pkg::level_type bright);
      logic stalled;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_hue_degrees  <= hue;
      req_sat_level    <= sat;
      req_bright_level <= bright;
      do begin
         @(negedge clock);
         stalled = req_stall;
         @(posedge clock);
      end while (stalled);
   endtask

   int phase_idle[4]  = '{0, 73, 0, 31};
   int phase_stall[4] = '{0, 0, 73, 31};

   initial begin
      hsvc_pkg::hue_type   hue;
      hsvc_pkg::level_type sat;
      hsvc_pkg::level_type bright;
      int                  pick;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Sector edges, a full turn, hues past a full turn and the grey case.
      send_pixel(9'd0, 8'd255, 8'd255);
      send_pixel(9'd59, 8'd255, 8'd255);
      send_pixel(9'd60, 8'd255, 8'd255);
      send_pixel(9'd119, 8'd200, 8'd255);
      send_pixel(9'd120, 8'd255, 8'd128);
      send_pixel(9'd179, 8'd1, 8'd255);
      send_pixel(9'd180, 8'd255, 8'd255);
      send_pixel(9'd240, 8'd127, 8'd254);
      send_pixel(9'd299, 8'd255, 8'd1);
      send_pixel(9'd300, 8'd255, 8'd255);
      send_pixel(9'd359, 8'd255, 8'd255);
      send_pixel(9'd360, 8'd255, 8'd255);
      send_pixel(9'd360, 8'd100, 8'd77);
      send_pixel(9'd361, 8'd255, 8'd255);
      send_pixel(9'd420, 8'd180, 8'd200);
      send_pixel(9'd480, 8'd255, 8'd255);
      send_pixel(9'd511, 8'd255, 8'd255);
      send_pixel(9'd511, 8'd0, 8'd170);
      send_pixel(9'd200, 8'd0, 8'd255);
      send_pixel(9'd0, 8'd0, 8'd0);
      send_pixel(9'd30, 8'd255, 8'd0);
      send_pixel(9'd256, 8'd85, 8'd85);

      for (int phase = 0; phase < 4; phase++) begin
         idle_pct  = phase_idle[phase];
         stall_pct = phase_stall[phase];
         for (int n = 0; n < RANDOM_ITEMS / 4; n++) begin
            pick = $urandom_range(99);
            if (pick < 6) begin
               hue = 9'd360;
            end else if (pick < 14) begin
               hue = hsvc_pkg::hue_type'($urandom_range(511, 361));
            end else if (pick < 24) begin
               hue = hsvc_pkg::hue_type'(60 * $urandom_range(5) + ($urandom_range(1) ? 59 : 0));
            end else begin
               hue = hsvc_pkg::hue_type'($urandom_range(359));
            end
            pick = $urandom_range(99);
            sat  = (pick < 8) ? 8'd0 : (pick < 18) ? 8'd255
                 : hsvc_pkg::level_type'($urandom_range(255));
            pick   = $urandom_range(99);
            bright = (pick < 5) ? 8'd0 : (pick < 15) ? 8'd255
                   : hsvc_pkg::level_type'($urandom_range(255));
            send_pixel(hue, sat, bright);
         end
      end
      req_valid <= 1'b0;

      do begin
         @(negedge clock);
      end while (colours_pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
